[rtl/vector2_polar_unit_assert.svh]
// ----------------------------------------------------------------------------
// vector2_polar_unit assertion macros
// Short forms for the concurrent checks on the unit's ports.
// ----------------------------------------------------------------------------
`ifndef VECTOR2_POLAR_UNIT_ASSERT_SVH
`define VECTOR2_POLAR_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define V2P_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define V2P_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also covers reset
`define V2P_ASSERT_RST(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/v2p_pkg.sv]
// ----------------------------------------------------------------------------
// v2p_pkg
// Shared constants, types and the arctangent table of the polar unit.
// ----------------------------------------------------------------------------
package v2p_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int ANGLE_BITS    = 16;
   localparam int GUARD         = 8;
   // datapath width of the CORDIC x/y registers
   localparam int XW            = 44;
   // width of the rotation angle accumulator
   localparam int ZW            = 34;
   localparam int MAG_W         = 34;

   localparam logic [31:0] GAIN_Q32  = 32'h9B74EDA8;
   localparam logic [31:0] HALF_TURN = 32'h80000000;
   localparam logic [31:0] ONE_Q16   = 32'h00010000;

   typedef enum logic [2:0] {
      ACT_ROTATE       = 3'd0,
      ACT_SET_HEADING  = 3'd1,
      ACT_SET_LENGTH   = 3'd2,
      ACT_NORMALIZE    = 3'd3,
      ACT_LEN_HEADING  = 3'd4,
      ACT_UNIT_HEADING = 3'd5,
      ACT_QUERY        = 3'd6
   } action_type;

   // everything an item carries down the pipeline
   typedef struct packed {
      logic [2:0]          action;
      logic signed [31:0]  in_x;
      logic signed [31:0]  in_y;
      logic [31:0]         ang;
      logic signed [31:0]  new_length;
      logic                zero;
      logic [MAG_W-1:0]    mag;
      logic [31:0]         head;
   } item_type;

   // rounded atan(2^-i) as a 32-bit binary angle
   function automatic logic [31:0] atan_at(input logic [4:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   // clamp a rounded component to the int32 range
   function automatic logic [31:0] sat32(input logic signed [XW-GUARD-1:0] v);
      logic [31:0] r;
      if (v > $signed((XW-GUARD)'(32'sh7FFFFFFF))) begin
         r = 32'h7FFFFFFF;
      end else if (v < -$signed((XW-GUARD)'(33'sh080000000))) begin
         r = 32'h80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[rtl/v2p_vector.sv]
// ----------------------------------------------------------------------------
// v2p_vector
// CORDIC vectoring pipeline: one register stage per iteration, after a
// stage that folds the vector into the right half plane.
// ----------------------------------------------------------------------------
module v2p_vector (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  v2p_pkg::item_type            in_item,
   output logic                         out_valid,
   output v2p_pkg::item_type            out_item,
   output logic signed [v2p_pkg::XW-1:0] out_x,
   output logic [31:0]                  out_z
);

   localparam int N = v2p_pkg::CORDIC_STAGES;

   logic                          vld_ff  [0:N];
   logic                          vld_in  [0:N];
   v2p_pkg::item_type             item_ff [0:N];
   v2p_pkg::item_type             item_in [0:N];
   logic signed [v2p_pkg::XW-1:0] x_ff    [0:N];
   logic signed [v2p_pkg::XW-1:0] x_in    [0:N];
   logic signed [v2p_pkg::XW-1:0] y_ff    [0:N];
   logic signed [v2p_pkg::XW-1:0] y_in    [0:N];
   logic [31:0]                   z_ff    [0:N];
   logic [31:0]                   z_in    [0:N];

   logic signed [v2p_pkg::XW-1:0] x_ext;
   logic signed [v2p_pkg::XW-1:0] y_ext;

   // scale by the guard bits and fold into the right half plane
   always_comb begin
      x_ext = $signed({{(v2p_pkg::XW-32){in_item.in_x[31]}}, in_item.in_x}) <<< v2p_pkg::GUARD;
      y_ext = $signed({{(v2p_pkg::XW-32){in_item.in_y[31]}}, in_item.in_y}) <<< v2p_pkg::GUARD;
      vld_in[0]  = in_valid;
      item_in[0] = in_item;
      if (x_ext < 0) begin
         x_in[0] = -x_ext;
         y_in[0] = -y_ext;
         z_in[0] = v2p_pkg::HALF_TURN;
      end else begin
         x_in[0] = x_ext;
         y_in[0] = y_ext;
         z_in[0] = '0;
      end
   end

   // one micro-rotation per stage, driving y toward zero
   for (genvar i = 0; i < N; i++) begin : g_stage
      always_comb begin
         vld_in[i+1]  = vld_ff[i];
         item_in[i+1] = item_ff[i];
         if (y_ff[i] >= 0) begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + v2p_pkg::atan_at(5'(i));
         end else begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - v2p_pkg::atan_at(5'(i));
         end
      end
   end

   // advance valid bits and payload together
   for (genvar k = 0; k <= N; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            item_ff[k] <= item_in[k];
            x_ff[k]    <= x_in[k];
            y_ff[k]    <= y_in[k];
            z_ff[k]    <= z_in[k];
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_item  = item_ff[N];
   assign out_x     = x_ff[N];
   assign out_z     = z_ff[N];

endmodule

[rtl/v2p_gain.sv]
// ----------------------------------------------------------------------------
// v2p_gain
// Gain correction of the vectoring result: split multiply, then add and
// round to the Q16.16 length. Zero vectors report length and heading 0.
// ----------------------------------------------------------------------------
module v2p_gain (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  v2p_pkg::item_type             in_item,
   input  logic signed [v2p_pkg::XW-1:0] in_x,
   input  logic [31:0]                   in_z,
   output logic                          out_valid,
   output v2p_pkg::item_type             out_item
);

   localparam int UW = v2p_pkg::XW - 2;
   localparam int HW = UW - 16;

   logic [UW-1:0]    ux;
   logic             vld1_ff;
   v2p_pkg::item_type item1_ff;
   logic [31:0]      head1_ff;
   logic [HW+31:0]   phi_ff;
   logic [HW+31:0]   phi_in;
   logic [47:0]      plo_ff;
   logic [47:0]      plo_in;
   logic             vld2_ff;
   v2p_pkg::item_type item2_ff;
   v2p_pkg::item_type item2_in;
   logic [HW+32:0]   t_sum;
   logic [HW+32:0]   t_rnd;

   // partial products of the clipped x with the gain constant
   always_comb begin
      ux     = in_x[v2p_pkg::XW-1] ? '0 : in_x[UW-1:0];
      phi_in = (HW+32)'(ux[UW-1:16]) * (HW+32)'(v2p_pkg::GAIN_Q32);
      plo_in = 48'(ux[15:0]) * 48'(v2p_pkg::GAIN_Q32);
   end

   // combine, round and drop the guard bits
   always_comb begin
      t_sum    = (HW+33)'(phi_ff) + (HW+33)'(plo_ff >> 16);
      t_rnd    = t_sum + (HW+33)'(1 << (16 + v2p_pkg::GUARD - 1));
      item2_in = item1_ff;
      if (item1_ff.zero) begin
         item2_in.mag  = '0;
         item2_in.head = '0;
      end else begin
         item2_in.mag  = v2p_pkg::MAG_W'(t_rnd >> (16 + v2p_pkg::GUARD));
         item2_in.head = head1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (advance) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item1_ff <= in_item;
         head1_ff <= in_z;
         phi_ff   <= phi_in;
         plo_ff   <= plo_in;
         item2_ff <= item2_in;
      end
   end

   assign out_valid = vld2_ff;
   assign out_item  = item2_ff;

endmodule

[rtl/v2p_rotate.sv]
// ----------------------------------------------------------------------------
// v2p_rotate
// Rebuild a vector from a length and a heading: gain-scaled start value,
// quadrant fold, then one CORDIC rotation stage per iteration.
// ----------------------------------------------------------------------------
module v2p_rotate (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic                                   in_valid,
   input  v2p_pkg::item_type                      in_item,
   input  logic [31:0]                            in_len,
   input  logic [31:0]                            in_ang,
   output logic                                   out_valid,
   output v2p_pkg::item_type                      out_item,
   output logic signed [v2p_pkg::XW-v2p_pkg::GUARD-1:0] out_x,
   output logic signed [v2p_pkg::XW-v2p_pkg::GUARD-1:0] out_y
);

   localparam int N  = v2p_pkg::CORDIC_STAGES;
   localparam int XW = v2p_pkg::XW;
   localparam int ZW = v2p_pkg::ZW;

   logic              pvld_ff;
   v2p_pkg::item_type pitem_ff;
   logic [63:0]       prod_ff;
   logic [31:0]       pang_ff;
   logic [63:0]       prod_rnd;
   logic signed [XW-1:0] x_start;
   logic [31:0]       ang_fold;
   logic [1:0]        quad;

   logic                 vld_ff  [0:N];
   logic                 vld_in  [0:N];
   v2p_pkg::item_type    item_ff [0:N];
   v2p_pkg::item_type    item_in [0:N];
   logic signed [XW-1:0] x_ff    [0:N];
   logic signed [XW-1:0] x_in    [0:N];
   logic signed [XW-1:0] y_ff    [0:N];
   logic signed [XW-1:0] y_in    [0:N];
   logic signed [ZW-1:0] z_ff    [0:N];
   logic signed [ZW-1:0] z_in    [0:N];

   logic signed [XW-1:0] x_rnd;
   logic signed [XW-1:0] y_rnd;

   // round the scaled length and fold the second and third quarters
   always_comb begin
      prod_rnd = prod_ff + 64'(1 << (31 - v2p_pkg::GUARD));
      x_start  = $signed(XW'(prod_rnd >> (32 - v2p_pkg::GUARD)));
      quad     = pang_ff[31:30];
      vld_in[0]  = pvld_ff;
      item_in[0] = pitem_ff;
      y_in[0]    = '0;
      if (quad == 2'd1 || quad == 2'd2) begin
         x_in[0]  = -x_start;
         ang_fold = pang_ff + v2p_pkg::HALF_TURN;
      end else begin
         x_in[0]  = x_start;
         ang_fold = pang_ff;
      end
      z_in[0] = $signed({{(ZW-32){ang_fold[31]}}, ang_fold});
   end

   // one micro-rotation per stage, driving z toward zero
   for (genvar i = 0; i < N; i++) begin : g_stage
      always_comb begin
         vld_in[i+1]  = vld_ff[i];
         item_in[i+1] = item_ff[i];
         if (z_ff[i] >= 0) begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - $signed(ZW'(v2p_pkg::atan_at(5'(i))));
         end else begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + $signed(ZW'(v2p_pkg::atan_at(5'(i))));
         end
      end
   end

   // multiply stage
   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= 1'b0;
      end else if (advance) begin
         pvld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pitem_ff <= in_item;
         pang_ff  <= in_ang;
         prod_ff  <= 64'(in_len) * 64'(v2p_pkg::GAIN_Q32);
      end
   end

   // fold stage and rotation stages
   for (genvar k = 0; k <= N; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            item_ff[k] <= item_in[k];
            x_ff[k]    <= x_in[k];
            y_ff[k]    <= y_in[k];
            z_ff[k]    <= z_in[k];
         end
      end
   end

   // round away the guard bits, ties up
   always_comb begin
      x_rnd = (x_ff[N] + XW'(1 << (v2p_pkg::GUARD - 1))) >>> v2p_pkg::GUARD;
      y_rnd = (y_ff[N] + XW'(1 << (v2p_pkg::GUARD - 1))) >>> v2p_pkg::GUARD;
   end

   assign out_valid = vld_ff[N];
   assign out_item  = item_ff[N];
   assign out_x     = x_rnd[XW-v2p_pkg::GUARD-1:0];
   assign out_y     = y_rnd[XW-v2p_pkg::GUARD-1:0];

endmodule

[rtl/vector2_polar_unit.sv]
// ----------------------------------------------------------------------------
// vector2_polar_unit
// Q16.16 2D vector unit: CORDIC vectoring for length and heading, CORDIC
// rotation to rebuild the vector for the requested action.
// ----------------------------------------------------------------------------
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_stall   action, in_x, in_y, angle, new_length
//   rsp_     out        rsp_valid/rsp_stall   out_x, out_y, old_length, old_heading
//
// One item per cycle while no stalled result waits at the output; stages in order: fold, vectoring
// stages, two gain stages, multiply, fold, rotation stages, output register.
// Reset clears all valid bits; no result appears until an item is taken.
// A stalled result freezes the whole pipeline; req_stall rises only while a
// result waits at the output and rsp_stall is high.
// ----------------------------------------------------------------------------
module vector2_polar_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_action,
   input  logic signed [31:0] req_in_x,
   input  logic signed [31:0] req_in_y,
   input  logic [15:0]        req_angle,
   input  logic signed [31:0] req_new_length,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic [30:0]        rsp_old_length,
   output logic [15:0]        rsp_old_heading
);

   localparam int RW = v2p_pkg::XW - v2p_pkg::GUARD;
   localparam int AB = v2p_pkg::ANGLE_BITS;

   logic              advance;
   v2p_pkg::item_type entry_item;
   logic              vec_valid;
   v2p_pkg::item_type vec_item;
   logic signed [v2p_pkg::XW-1:0] vec_x;
   logic [31:0]       vec_z;
   logic              gain_valid;
   v2p_pkg::item_type gain_item;
   logic [31:0]       sel_len;
   logic [31:0]       sel_ang;
   logic [31:0]       mag_clip;
   logic [31:0]       nl_abs;
   logic              rot_valid;
   v2p_pkg::item_type rot_item;
   logic signed [RW-1:0] rot_x;
   logic signed [RW-1:0] rot_y;
   logic [31:0]       head_rnd;

   logic              rsp_valid_ff;
   logic [31:0]       out_x_ff;
   logic [31:0]       out_x_in;
   logic [31:0]       out_y_ff;
   logic [31:0]       out_y_in;
   logic [30:0]       len_ff;
   logic [30:0]       len_in;
   logic [15:0]       head_ff;
   logic [15:0]       head_in;

   // move everything whenever the output register can take a result
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // pack the incoming item
   always_comb begin
      entry_item            = '0;
      entry_item.action     = req_action;
      entry_item.in_x       = req_in_x;
      entry_item.in_y       = req_in_y;
      entry_item.ang        = {req_angle[AB-1:0], (32-AB)'(0)};
      entry_item.new_length = req_new_length;
      entry_item.zero       = (req_in_x == 0) && (req_in_y == 0);
   end

   v2p_vector u_vector (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_item   (entry_item),
      .out_valid (vec_valid),
      .out_item  (vec_item),
      .out_x     (vec_x),
      .out_z     (vec_z)
   );

   v2p_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (vec_valid),
      .in_item   (vec_item),
      .in_x      (vec_x),
      .in_z      (vec_z),
      .out_valid (gain_valid),
      .out_item  (gain_item)
   );

   // pick length and heading for the rebuild
   always_comb begin
      mag_clip = (gain_item.mag[v2p_pkg::MAG_W-1:32] != 0) ? 32'hFFFFFFFF
                                                            : gain_item.mag[31:0];
      nl_abs   = gain_item.new_length[31] ? (~gain_item.new_length + 32'd1)
                                          : gain_item.new_length;
      unique case (gain_item.action)
         v2p_pkg::ACT_ROTATE: begin
            sel_len = mag_clip;
            sel_ang = gain_item.head + gain_item.ang;
         end
         v2p_pkg::ACT_SET_HEADING: begin
            sel_len = mag_clip;
            sel_ang = gain_item.ang;
         end
         v2p_pkg::ACT_SET_LENGTH: begin
            sel_len = nl_abs;
            sel_ang = gain_item.new_length[31] ? gain_item.head + v2p_pkg::HALF_TURN
                                               : gain_item.head;
         end
         v2p_pkg::ACT_NORMALIZE: begin
            sel_len = v2p_pkg::ONE_Q16;
            sel_ang = gain_item.head;
         end
         v2p_pkg::ACT_LEN_HEADING: begin
            sel_len = nl_abs;
            sel_ang = gain_item.ang;
         end
         v2p_pkg::ACT_UNIT_HEADING: begin
            sel_len = v2p_pkg::ONE_Q16;
            sel_ang = gain_item.ang;
         end
         default: begin
            sel_len = '0;
            sel_ang = '0;
         end
      endcase
   end

   v2p_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (gain_valid),
      .in_item   (gain_item),
      .in_len    (sel_len),
      .in_ang    (sel_ang),
      .out_valid (rot_valid),
      .out_item  (rot_item),
      .out_x     (rot_x),
      .out_y     (rot_y)
   );

   // choose the result, saturate, round the heading
   always_comb begin
      priority if (rot_item.action == v2p_pkg::ACT_QUERY ||
                   rot_item.action > v2p_pkg::ACT_QUERY) begin
         out_x_in = rot_item.in_x;
         out_y_in = rot_item.in_y;
      end else if (rot_item.zero && (rot_item.action == v2p_pkg::ACT_NORMALIZE ||
                                     rot_item.action == v2p_pkg::ACT_UNIT_HEADING)) begin
         out_x_in = '0;
         out_y_in = '0;
      end else begin
         out_x_in = v2p_pkg::sat32(rot_x);
         out_y_in = v2p_pkg::sat32(rot_y);
      end
      len_in   = (rot_item.mag > v2p_pkg::MAG_W'(32'h7FFFFFFF)) ? 31'h7FFFFFFF
                                                              : rot_item.mag[30:0];
      head_rnd = rot_item.head + (32'd1 << (31 - AB));
      head_in  = 16'(head_rnd >> (32 - AB));
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rot_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         len_ff   <= len_in;
         head_ff  <= head_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = out_x_ff;
   assign rsp_out_y       = out_y_ff;
   assign rsp_old_length  = len_ff;
   assign rsp_old_heading = head_ff;

endmodule

[rtl/v2p_checker.sv]
// ----------------------------------------------------------------------------
// v2p_checker
// Port-level checks of the polar unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "vector2_polar_unit_assert.svh"

module v2p_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_out_x,
   input logic signed [31:0] rsp_out_y,
   input logic [30:0]        rsp_old_length,
   input logic [15:0]        rsp_old_heading
);

   // input is held back only while a result waits at a stalled output
   `V2P_ASSERT_IMP(a_stall_cause, req_stall, rsp_valid && rsp_stall, "req_stall without output backpressure")

   // a stalled result stays put
   `V2P_ASSERT_NXT(a_hold_result, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_old_length) && $stable(rsp_old_heading), "stalled result changed")

   // nothing is in flight right after reset
   `V2P_ASSERT_RST(a_reset_empty, reset, !rsp_valid, "result valid after reset")

   // an idle output never pushes back on the input
   `V2P_ASSERT_IMP(a_free_input, !rsp_valid, !req_stall, "input stalled with empty output")

endmodule

bind vector2_polar_unit v2p_checker u_v2p_checker (.*);
